/* hw/rtl/srdg_pkg.sv */
// Shared types and constants for the stepper ramp delay generator.
package srdg_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned OutDlyW  = 24;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Request to the serial divider
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  // Answer from the serial divider
  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/srdg_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module srdg_div
  import srdg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW-1:0]   quo_q, quo_d;
  logic [DataW-1:0]   den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DataW:0] shifted;
  logic [DataW:0] diff;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[DataW-1]};
    diff    = shifted - {1'b0, den_q};
    if (!diff[DataW]) begin
      rem_d = diff[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], 1'b1};
    end else begin
      rem_d = shifted[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hw/rtl/stepper_ramp_delay_generator.sv */
// Stepper ramp delay generator: sequencer, ramp state and result register.
//
// Channel  Dir  Handshake                  Word
// in       in   in_valid_i / in_ready_o    target_position_i, cruise_delay_i
// out      out  out_valid_o / out_ready_i  step_delay_o, steps_done_o,
//                                          ramp_index_o, cruising_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_first_delay_i
//
// A ramp step (speed up or slow down) passes from accept through the evaluate
// state, the serial divider and the update, then loads the result register.
// Stop, first step, hold and cruise words skip the divider. The input is taken
// only while the sequencer is idle, which it reenters as the result register
// loads; a result waiting on out_ready_i does not block the next accept, and a
// finished word waits in the post stage until the result register frees.
// Reset is asynchronous, active low, and clears all ramp state.
module stepper_ramp_delay_generator
  import srdg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DataW-1:0]   target_position_i,
  input  logic [DataW-1:0]   cruise_delay_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OutDlyW-1:0] step_delay_o,
  output logic [DataW-1:0]   steps_done_o,
  output logic [DataW-1:0]   ramp_index_o,
  output logic               cruising_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DataW-1:0]   cfg_first_delay_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StPost = 2'd3;

  localparam logic [1:0] RampFast  = 2'd0;
  localparam logic [1:0] RampSlow  = 2'd1;
  localparam logic [1:0] RampBrake = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [DataW-1:0] first_dly_q;
  logic [DataW-1:0] tgt_q, cruise_q;
  logic [DataW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] ramp_q, ramp_d;
  logic [DataW-1:0] cur_q, cur_d;
  logic [DataW-1:0] slew_q, slew_d;
  logic [DataW-1:0] dly_q, dly_d;

  logic               out_valid_q;
  logic [OutDlyW-1:0] out_dly_q;
  logic [DataW-1:0]   out_cnt_q, out_ramp_q;
  logic               out_cruise_q;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [DataW-1:0] slew_kept, est, q_div, cur_new, start_dly;
  logic             in_fire, out_free, stop_req;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  srdg_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // evaluate and update rules
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    ramp_d  = ramp_q;
    cur_d   = cur_q;
    slew_d  = slew_q;
    dly_d   = dly_q;

    stop_req  = (cnt_q >= tgt_q) && (ramp_q <= DataW'(1));
    slew_kept = (slew_q != cruise_q) ? '0 : slew_q;
    est       = cnt_q + ramp_q;
    start_dly = (first_dly_q < cruise_q) ? cruise_q : first_dly_q;
    q_div     = '0;
    cur_new   = (mode_q == RampFast) ? cur_q - div_rsp.quotient
                                     : cur_q + div_rsp.quotient;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) state_d = StEval;
      end
      StEval: begin
        state_d = StPost;
        if (stop_req) begin
          ramp_d = '0;
          dly_d  = '0;
        end else begin
          slew_d = slew_kept;
          cnt_d  = cnt_q + 1'b1;
          dly_d  = (slew_kept != '0) ? slew_kept : cur_q;
          if (ramp_q == '0) begin
            cur_d  = start_dly;
            ramp_d = DataW'(1);
            dly_d  = start_dly;
          end else if (est == tgt_q) begin
            // hold current delay
          end else if (est > tgt_q) begin
            mode_d  = RampBrake;
            state_d = StDiv;
          end else if (slew_kept == '0 && cur_q < cruise_q) begin
            mode_d  = RampSlow;
            state_d = StDiv;
          end else if (slew_kept == '0 && cur_q > cruise_q) begin
            mode_d  = RampFast;
            state_d = StDiv;
          end
          if (state_d == StDiv) begin
            if (mode_d != RampFast) ramp_d = ramp_q - 1'b1;
            // 4n+1 when speeding up, 4(n-1)-1 when slowing down
            q_div = (mode_d == RampFast) ? {ramp_q[DataW-3:0], 2'b01}
                                         : {ramp_q[DataW-3:0], 2'b00} - DataW'(5);
            div_req.start    = 1'b1;
            div_req.divisor  = q_div;
            div_req.dividend = {cur_q[DataW-2:0], 1'b0} + {1'b0, q_div[DataW-1:1]};
          end
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          state_d = StPost;
          cur_d   = cur_new;
          case (mode_q)
            RampFast: begin
              ramp_d = ramp_q + 1'b1;
              if (cur_new <= cruise_q) slew_d = cruise_q;
            end
            RampSlow: begin
              if (cur_new >= cruise_q) slew_d = cruise_q;
            end
            default: slew_d = '0;
          endcase
          dly_d = (slew_d != '0) ? slew_d : cur_new;
        end
      end
      StPost: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control and ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= RampFast;
      first_dly_q <= '0;
      cnt_q       <= '0;
      ramp_q      <= '0;
      cur_q       <= '0;
      slew_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      ramp_q  <= ramp_d;
      cur_q   <= cur_d;
      slew_q  <= slew_d;
      if (cfg_valid_i) first_dly_q <= cfg_first_delay_i;
      if (state_q == StPost && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request word and result word
  always_ff @(posedge clk_i) begin
    dly_q <= dly_d;
    if (in_fire) begin
      tgt_q    <= target_position_i;
      cruise_q <= cruise_delay_i;
    end
    if (state_q == StPost && out_free) begin
      out_dly_q    <= dly_q[DataW-1:DataW-OutDlyW];
      out_cnt_q    <= cnt_q;
      out_ramp_q   <= ramp_q;
      out_cruise_q <= (slew_q != '0);
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign step_delay_o = out_dly_q;
  assign steps_done_o = out_cnt_q;
  assign ramp_index_o = out_ramp_q;
  assign cruising_o   = out_cruise_q;

endmodule

/* hw/rtl/srdg_chk.sv */
// Port-level checks for the stepper ramp delay generator, bound to the top.
module srdg_chk
  import srdg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [OutDlyW-1:0] step_delay_o,
  input logic [DataW-1:0]   steps_done_o
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its step count and delay
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(steps_done_o) && $stable(step_delay_o))
    else $error("result word changed while stalled");

  // the block works on one request word at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // no result appears in the cycle right after an accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result word too early");

endmodule

bind stepper_ramp_delay_generator srdg_chk u_srdg_chk (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .step_delay_o,
  .steps_done_o
);
